// ===== hdl/sdi_pkg.sv =====
// Shared definitions for the dual sorted interval index.
// Request and status codes, key table operations, default sizes.
// No dependencies.
package sdi_pkg;

  localparam int MAX_ITEMS_DEF = 256;
  localparam int KEY_BITS_DEF  = 32;
  localparam int ID_BITS       = 8;
  localparam int ID_COUNT      = 256;
  localparam int POS_BITS      = 32;
  localparam int RES_IDX_BITS  = 9;

  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_REMOVE    = 3'd1;
  localparam logic [2:0] REQ_CHG_BEGIN = 3'd2;
  localparam logic [2:0] REQ_CHG_END   = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;
  localparam logic [2:0] REQ_FIND      = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    OP_LB   = 2'd0,
    OP_ADD  = 2'd1,
    OP_DROP = 2'd2
  } tab_op_t;

  typedef struct packed {
    logic    start;
    tab_op_t op;
  } tab_cmd_t;

endpackage

// ===== hdl/dual_sorted_interval_index.sv =====
// Dual sorted interval index: top level with request sequencer and item table.
// Depends on sdi_pkg, sdi_ram and sdi_tab.
//
// One request is taken at a time and answered by exactly one result. The
// item table (begin and end key per item id) sits in a RAM; the valid bit of
// each id is a flip-flop cleared by reset and by a clear request. Each of the
// two key tables (distinct begin keys, distinct end keys, each with a count)
// lives in its own RAM and is searched by a linear lower-bound scan of one
// entry a cycle; inserting or deleting a distinct key shifts the entries above
// it one place, one entry a cycle. A change runs a drop and then an add on
// the same table, each a scan and a shift of about one pass over the table.
// A clear, an unknown code or a rejected request starts no scan and goes
// from dispatch straight to the result stage. The next request is taken
// while a result still waits on a stalled output.
module dual_sorted_interval_index #(
  parameter int MAX_ITEMS = sdi_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = sdi_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_item_id,
  input  logic [31:0] in_begin_pos,
  input  logic [31:0] in_end_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [8:0]  out_begin_index,
  output logic [8:0]  out_end_index,
  output logic [8:0]  out_old_index,
  output logic        out_found,
  output logic [8:0]  out_item_count,
  output logic [31:0] out_first_begin,
  output logic [31:0] out_last_end,
  output logic        out_begins_serial,
  output logic        out_ends_serial
);

  localparam int IDX_W = $clog2(MAX_ITEMS + 1);
  localparam int RW    = sdi_pkg::RES_IDX_BITS;
  localparam int IDN   = sdi_pkg::ID_COUNT;
  localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] MAXV = IDX_W'(MAX_ITEMS);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    T_IDLE  = 6'b000001,
    T_DISP  = 6'b000010,
    T_WAIT  = 6'b000100,
    T_ADD2  = 6'b001000,
    T_WAIT2 = 6'b010000,
    T_FIN   = 6'b100000
  } top_state_t;

  top_state_t st_r, st_nxt;

  // latched request
  logic [2:0]          req_r, req_nxt;
  logic [7:0]          id_r, id_nxt;
  logic [KEY_BITS-1:0] kb_r, kb_nxt, ke_r, ke_nxt;

  // item state
  logic [IDN-1:0]   valid_r, valid_nxt;
  logic [IDX_W-1:0] held_r, held_nxt;

  // result being built
  logic [1:0]    res_st_r, res_st_nxt;
  logic [RW-1:0] res_b_r, res_b_nxt, res_e_r, res_e_nxt, res_o_r, res_o_nxt;
  logic          res_f_r, res_f_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    o_st_r, o_st_nxt;
  logic [RW-1:0] o_b_r, o_b_nxt, o_e_r, o_e_nxt, o_o_r, o_o_nxt, o_cnt_r, o_cnt_nxt;
  logic          o_f_r, o_f_nxt, o_bs_r, o_bs_nxt, o_es_r, o_es_nxt;
  logic [31:0]   o_fb_r, o_fb_nxt, o_le_r, o_le_nxt;

  // item RAM
  logic                  it_we;
  logic [2*KEY_BITS-1:0] it_wdata, it_rdata;
  logic [KEY_BITS-1:0]   ib_q, ie_q;
  logic                  present;

  // key tables
  sdi_pkg::tab_cmd_t   b_cmd, e_cmd;
  logic [KEY_BITS-1:0] b_key, e_key, b_bnd, e_bnd;
  logic                b_busy, e_busy, b_ser, e_ser, tab_clr;
  logic [IDX_W-1:0]    b_idx, e_idx, b_used, e_used;

  // width adaption
  logic [95:0]          kb_ext, ke_ext;
  logic [IDX_W+RW-1:0]  b_idx_ext, e_idx_ext, held_ext;
  logic [RW-1:0]        b_idx9, e_idx9, held9;
  logic [KEY_BITS+31:0] fb_ext, le_ext;

  assign kb_ext    = {{64{in_begin_pos[31]}}, in_begin_pos};
  assign ke_ext    = {{64{in_end_pos[31]}}, in_end_pos};
  assign b_idx_ext = {{RW{1'b0}}, b_idx};
  assign e_idx_ext = {{RW{1'b0}}, e_idx};
  assign held_ext  = {{RW{1'b0}}, held_nxt};
  assign b_idx9    = b_idx_ext[RW-1:0];
  assign e_idx9    = e_idx_ext[RW-1:0];
  assign held9     = held_ext[RW-1:0];
  assign fb_ext    = {{32{b_bnd[KEY_BITS-1]}}, b_bnd};
  assign le_ext    = {{32{e_bnd[KEY_BITS-1]}}, e_bnd};

  assign ib_q    = it_rdata[2*KEY_BITS-1 -: KEY_BITS];
  assign ie_q    = it_rdata[KEY_BITS-1:0];
  assign present = valid_r[id_r];

  // read address follows the request port, so the entry is ready in T_DISP
  sdi_ram #(.WIDTH(2 * KEY_BITS), .DEPTH(IDN)) u_items (
    .clk   (clk),
    .we    (it_we),
    .waddr (id_r),
    .wdata (it_wdata),
    .raddr (in_item_id),
    .rdata (it_rdata)
  );

  sdi_tab #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS), .BND_LAST(1'b0)) u_btab (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (b_cmd),
    .clr    (tab_clr),
    .key    (b_key),
    .busy   (b_busy),
    .idx    (b_idx),
    .used   (b_used),
    .serial (b_ser),
    .bnd    (b_bnd)
  );

  sdi_tab #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS), .BND_LAST(1'b1)) u_etab (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (e_cmd),
    .clr    (tab_clr),
    .key    (e_key),
    .busy   (e_busy),
    .idx    (e_idx),
    .used   (e_used),
    .serial (e_ser),
    .bnd    (e_bnd)
  );

  always_comb begin
    st_nxt     = st_r;
    req_nxt    = req_r;
    id_nxt     = id_r;
    kb_nxt     = kb_r;
    ke_nxt     = ke_r;
    valid_nxt  = valid_r;
    held_nxt   = held_r;
    res_st_nxt = res_st_r;
    res_b_nxt  = res_b_r;
    res_e_nxt  = res_e_r;
    res_o_nxt  = res_o_r;
    res_f_nxt  = res_f_r;
    it_we      = 1'b0;
    it_wdata   = {kb_r, ke_r};
    b_cmd      = '{start: 1'b0, op: sdi_pkg::OP_LB};
    e_cmd      = '{start: 1'b0, op: sdi_pkg::OP_LB};
    b_key      = kb_r;
    e_key      = ke_r;
    tab_clr    = 1'b0;

    out_valid_nxt = out_valid_r;
    o_st_nxt  = o_st_r;
    o_b_nxt   = o_b_r;
    o_e_nxt   = o_e_r;
    o_o_nxt   = o_o_r;
    o_f_nxt   = o_f_r;
    o_cnt_nxt = o_cnt_r;
    o_fb_nxt  = o_fb_r;
    o_le_nxt  = o_le_r;
    o_bs_nxt  = o_bs_r;
    o_es_nxt  = o_es_r;

    // drop the output once it is taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          id_nxt     = in_item_id;
          kb_nxt     = kb_ext[KEY_BITS-1:0];
          ke_nxt     = ke_ext[KEY_BITS-1:0];
          res_st_nxt = sdi_pkg::ST_DONE;
          res_b_nxt  = '0;
          res_e_nxt  = '0;
          res_o_nxt  = '0;
          res_f_nxt  = 1'b0;
          st_nxt     = T_DISP;
        end
      end
      T_DISP: begin
        st_nxt = T_FIN;
        case (req_r)
          sdi_pkg::REQ_INSERT: begin
            if (present) begin
              res_st_nxt = sdi_pkg::ST_PRESENT;
            end else if (held_r >= MAXV) begin
              res_st_nxt = sdi_pkg::ST_FULL;
            end else begin
              it_we         = 1'b1;
              valid_nxt[id_r] = 1'b1;
              held_nxt      = held_r + ONE;
              b_cmd         = '{start: 1'b1, op: sdi_pkg::OP_ADD};
              e_cmd         = '{start: 1'b1, op: sdi_pkg::OP_ADD};
              st_nxt        = T_WAIT;
            end
          end
          sdi_pkg::REQ_REMOVE: begin
            if (!present) begin
              res_st_nxt = sdi_pkg::ST_PRESENT;
            end else begin
              valid_nxt[id_r] = 1'b0;
              held_nxt      = held_r - ONE;
              b_cmd         = '{start: 1'b1, op: sdi_pkg::OP_DROP};
              e_cmd         = '{start: 1'b1, op: sdi_pkg::OP_DROP};
              b_key         = ib_q;
              e_key         = ie_q;
              st_nxt        = T_WAIT;
            end
          end
          sdi_pkg::REQ_CHG_BEGIN: begin
            if (!present) begin
              res_st_nxt = sdi_pkg::ST_PRESENT;
            end else begin
              it_we    = 1'b1;
              it_wdata = {kb_r, ie_q};
              b_cmd    = '{start: 1'b1, op: sdi_pkg::OP_DROP};
              e_cmd    = '{start: 1'b1, op: sdi_pkg::OP_LB};
              b_key    = ib_q;
              e_key    = ie_q;
              st_nxt   = T_WAIT;
            end
          end
          sdi_pkg::REQ_CHG_END: begin
            if (!present) begin
              res_st_nxt = sdi_pkg::ST_PRESENT;
            end else begin
              it_we    = 1'b1;
              it_wdata = {ib_q, ke_r};
              b_cmd    = '{start: 1'b1, op: sdi_pkg::OP_LB};
              e_cmd    = '{start: 1'b1, op: sdi_pkg::OP_DROP};
              b_key    = ib_q;
              e_key    = ie_q;
              st_nxt   = T_WAIT;
            end
          end
          sdi_pkg::REQ_CLEAR: begin
            valid_nxt = '0;
            held_nxt  = '0;
            tab_clr   = 1'b1;
          end
          sdi_pkg::REQ_FIND: begin
            res_f_nxt = present;
            b_cmd     = '{start: 1'b1, op: sdi_pkg::OP_LB};
            e_cmd     = '{start: 1'b1, op: sdi_pkg::OP_LB};
            b_key     = present ? ib_q : kb_r;
            e_key     = present ? ie_q : ke_r;
            st_nxt    = T_WAIT;
          end
          default: st_nxt = T_FIN;
        endcase
      end
      T_WAIT: begin
        if (!b_busy && !e_busy) begin
          case (req_r)
            sdi_pkg::REQ_CHG_BEGIN: begin
              res_o_nxt = b_idx9;
              res_e_nxt = e_idx9;
              st_nxt    = T_ADD2;
            end
            sdi_pkg::REQ_CHG_END: begin
              res_o_nxt = e_idx9;
              res_b_nxt = b_idx9;
              st_nxt    = T_ADD2;
            end
            default: begin
              res_b_nxt = b_idx9;
              res_e_nxt = e_idx9;
              st_nxt    = T_FIN;
            end
          endcase
        end
      end
      T_ADD2: begin
        // second half of a change: add the new key to the same table
        if (req_r == sdi_pkg::REQ_CHG_BEGIN) b_cmd = '{start: 1'b1, op: sdi_pkg::OP_ADD};
        else e_cmd = '{start: 1'b1, op: sdi_pkg::OP_ADD};
        st_nxt = T_WAIT2;
      end
      T_WAIT2: begin
        if (!b_busy && !e_busy) begin
          if (req_r == sdi_pkg::REQ_CHG_BEGIN) res_b_nxt = b_idx9;
          else res_e_nxt = e_idx9;
          st_nxt = T_FIN;
        end
      end
      T_FIN: begin
        // hold here only while an earlier result still waits
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_st_nxt  = res_st_r;
          o_b_nxt   = res_b_r;
          o_e_nxt   = res_e_r;
          o_o_nxt   = res_o_r;
          o_f_nxt   = res_f_r;
          o_cnt_nxt = held9;
          o_fb_nxt  = (b_used == '0) ? 32'd0 : fb_ext[31:0];
          o_le_nxt  = (e_used == '0) ? 32'd0 : le_ext[31:0];
          o_bs_nxt  = b_ser;
          o_es_nxt  = e_ser;
          st_nxt    = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      valid_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    kb_r     <= kb_nxt;
    ke_r     <= ke_nxt;
    res_st_r <= res_st_nxt;
    res_b_r  <= res_b_nxt;
    res_e_r  <= res_e_nxt;
    res_o_r  <= res_o_nxt;
    res_f_r  <= res_f_nxt;
    o_st_r   <= o_st_nxt;
    o_b_r    <= o_b_nxt;
    o_e_r    <= o_e_nxt;
    o_o_r    <= o_o_nxt;
    o_f_r    <= o_f_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_fb_r   <= o_fb_nxt;
    o_le_r   <= o_le_nxt;
    o_bs_r   <= o_bs_nxt;
    o_es_r   <= o_es_nxt;
  end

  assign in_stall          = (st_r != T_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = o_st_r;
  assign out_begin_index   = o_b_r;
  assign out_end_index     = o_e_r;
  assign out_old_index     = o_o_r;
  assign out_found         = o_f_r;
  assign out_item_count    = o_cnt_r;
  assign out_first_begin   = o_fb_r;
  assign out_last_end      = o_le_r;
  assign out_begins_serial = o_bs_r;
  assign out_ends_serial   = o_es_r;

endmodule

// ===== hdl/sdi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sdi_tab.sv =====
// Sorted key table with per-key counts, held in one sdi_ram.
// Linear lower-bound scan, shift passes for insert and delete.
// Depends on sdi_pkg and sdi_ram.
module sdi_tab #(
  parameter int MAX_ITEMS = sdi_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = sdi_pkg::KEY_BITS_DEF,
  parameter bit BND_LAST  = 1'b0,
  localparam int IDX_W = $clog2(MAX_ITEMS + 1),
  localparam int AW    = $clog2(MAX_ITEMS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdi_pkg::tab_cmd_t    cmd,
  input  logic                 clr,
  input  logic [KEY_BITS-1:0]  key,
  output logic                 busy,
  output logic [IDX_W-1:0]     idx,
  output logic [IDX_W-1:0]     used,
  output logic                 serial,
  output logic [KEY_BITS-1:0]  bnd
);

  localparam int DW = KEY_BITS + IDX_W;
  localparam logic [IDX_W-1:0] ONE = IDX_W'(1);
  localparam logic [IDX_W-1:0] TWO = IDX_W'(2);
  localparam logic [IDX_W-1:0] MAXV = IDX_W'(MAX_ITEMS);

  typedef enum logic [7:0] {
    E_IDLE = 8'b00000001,
    E_SCAN = 8'b00000010,
    E_UPD  = 8'b00000100,
    E_SHUP = 8'b00001000,
    E_INS  = 8'b00010000,
    E_SHDN = 8'b00100000,
    E_BND  = 8'b01000000,
    E_BNDW = 8'b10000000
  } tab_state_t;

  tab_state_t       st_r, st_nxt;
  sdi_pkg::tab_op_t op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt, bnd_r, bnd_nxt;
  logic [IDX_W-1:0] used_r, used_nxt, dup_r, dup_nxt, idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt, ra_r, ra_nxt, pi_r, pi_nxt;
  logic             hit_r, hit_nxt, iss_r, iss_nxt, pv_r, pv_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DW-1:0]    wdata, rdata;
  logic [KEY_BITS-1:0] q_key;
  logic [IDX_W-1:0] q_cnt, pi_p1, pi_m1, used_m1;

  assign q_key   = rdata[DW-1 -: KEY_BITS];
  assign q_cnt   = rdata[IDX_W-1:0];
  assign pi_p1   = pi_r + ONE;
  assign pi_m1   = pi_r - ONE;
  assign used_m1 = used_r - ONE;

  sdi_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    key_nxt  = key_r;
    bnd_nxt  = bnd_r;
    used_nxt = used_r;
    dup_nxt  = dup_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    ra_nxt   = ra_r;
    pi_nxt   = pi_r;
    hit_nxt  = hit_r;
    iss_nxt  = iss_r;
    pv_nxt   = pv_r;
    we       = 1'b0;
    waddr    = idx_r[AW-1:0];
    wdata    = {key_r, cnt_r};
    raddr    = ra_r[AW-1:0];
    case (st_r)
      E_IDLE: begin
        if (cmd.start) begin
          op_nxt  = cmd.op;
          key_nxt = key;
          if (used_r == '0) begin
            idx_nxt = '0;
            hit_nxt = 1'b0;
            st_nxt  = E_UPD;
          end else begin
            ra_nxt  = '0;
            iss_nxt = 1'b1;
            pv_nxt  = 1'b0;
            st_nxt  = E_SCAN;
          end
        end
      end
      E_SCAN: begin
        // issue one read a cycle, compare the entry that returns
        if (iss_r) begin
          pv_nxt = 1'b1;
          pi_nxt = ra_r;
          if (ra_r == used_m1) iss_nxt = 1'b0;
          else ra_nxt = ra_r + ONE;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if ($signed(q_key) >= $signed(key_r)) begin
            idx_nxt = pi_r;
            hit_nxt = (q_key == key_r);
            cnt_nxt = q_cnt;
            iss_nxt = 1'b0;
            pv_nxt  = 1'b0;
            st_nxt  = E_UPD;
          end else if (pi_r == used_m1) begin
            idx_nxt = used_r;
            hit_nxt = 1'b0;
            iss_nxt = 1'b0;
            pv_nxt  = 1'b0;
            st_nxt  = E_UPD;
          end
        end
      end
      E_UPD: begin
        case (op_r)
          sdi_pkg::OP_ADD: begin
            if (hit_r) begin
              we    = 1'b1;
              wdata = {key_r, cnt_r + ONE};
              if (cnt_r == ONE) dup_nxt = dup_r + ONE;
              st_nxt = E_BND;
            end else if (used_r >= MAXV) begin
              st_nxt = E_IDLE;
            end else if (idx_r == used_r) begin
              st_nxt = E_INS;
            end else begin
              ra_nxt  = used_m1;
              iss_nxt = 1'b1;
              pv_nxt  = 1'b0;
              st_nxt  = E_SHUP;
            end
          end
          sdi_pkg::OP_DROP: begin
            if (!hit_r) begin
              st_nxt = E_IDLE;
            end else if (cnt_r > ONE) begin
              we    = 1'b1;
              wdata = {key_r, cnt_r - ONE};
              if (cnt_r == TWO) dup_nxt = dup_r - ONE;
              st_nxt = E_BND;
            end else if (idx_r == used_m1) begin
              used_nxt = used_m1;
              st_nxt   = E_BND;
            end else begin
              ra_nxt  = idx_r + ONE;
              iss_nxt = 1'b1;
              pv_nxt  = 1'b0;
              st_nxt  = E_SHDN;
            end
          end
          default: st_nxt = E_IDLE;
        endcase
      end
      E_SHUP: begin
        // move entries up one place, from the top down to the gap
        if (iss_r) begin
          pv_nxt = 1'b1;
          pi_nxt = ra_r;
          if (ra_r == idx_r) iss_nxt = 1'b0;
          else ra_nxt = ra_r - ONE;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          we    = 1'b1;
          waddr = pi_p1[AW-1:0];
          wdata = rdata;
          if (pi_r == idx_r) begin
            pv_nxt = 1'b0;
            st_nxt = E_INS;
          end
        end
      end
      E_INS: begin
        we       = 1'b1;
        wdata    = {key_r, ONE};
        used_nxt = used_r + ONE;
        st_nxt   = E_BND;
      end
      E_SHDN: begin
        // close the gap: move entries down one place
        if (iss_r) begin
          pv_nxt = 1'b1;
          pi_nxt = ra_r;
          if (ra_r == used_m1) iss_nxt = 1'b0;
          else ra_nxt = ra_r + ONE;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          we    = 1'b1;
          waddr = pi_m1[AW-1:0];
          wdata = rdata;
          if (pi_r == used_m1) begin
            pv_nxt   = 1'b0;
            used_nxt = used_m1;
            st_nxt   = E_BND;
          end
        end
      end
      E_BND: begin
        raddr  = BND_LAST ? used_m1[AW-1:0] : '0;
        st_nxt = E_BNDW;
      end
      E_BNDW: begin
        bnd_nxt = q_key;
        st_nxt  = E_IDLE;
      end
      default: st_nxt = E_IDLE;
    endcase
    if (clr) begin
      used_nxt = '0;
      dup_nxt  = '0;
      iss_nxt  = 1'b0;
      pv_nxt   = 1'b0;
      st_nxt   = E_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      used_r <= '0;
      dup_r  <= '0;
      iss_r  <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      used_r <= used_nxt;
      dup_r  <= dup_nxt;
      iss_r  <= iss_nxt;
      pv_r   <= pv_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    bnd_r <= bnd_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    ra_r  <= ra_nxt;
    pi_r  <= pi_nxt;
    hit_r <= hit_nxt;
  end

  assign busy   = (st_r != E_IDLE);
  assign idx    = idx_r;
  assign used   = used_r;
  assign serial = (dup_r == '0);
  assign bnd    = bnd_r;

endmodule

// ===== hdl/sdi_chk.sv =====
// Port-level checker for dual_sorted_interval_index, bound to the top level.
// Depends on sdi_pkg.
module sdi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [8:0]  out_item_count,
  input logic [31:0] out_first_begin,
  input logic [31:0] out_last_end,
  input logic        out_begins_serial,
  input logic        out_ends_serial
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == sdi_pkg::ST_DONE || out_status == sdi_pkg::ST_PRESENT ||
                  out_status == sdi_pkg::ST_FULL)
    else $error("undefined status code");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == sdi_pkg::ST_DONE)
    else $error("found with failing status");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_count == 9'd0 |->
      out_first_begin == 32'd0 && out_last_end == 32'd0 &&
      out_begins_serial && out_ends_serial)
    else $error("empty index reports keys or shared keys");

endmodule

bind dual_sorted_interval_index sdi_chk u_sdi_chk (.*);

// ===== bench/interval_index_checker.sv =====
`timescale 1ns / 100ps
// Checker for the dual sorted interval index: watches both channels, predicts
// each result from its own copy of the item and key tables, and compares.
// Depends on sdi_pkg for request and status codes.
module interval_index_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_item_id,
  input  logic [31:0] in_begin_pos,
  input  logic [31:0] in_end_pos,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [8:0]  out_begin_index,
  input  logic [8:0]  out_end_index,
  input  logic [8:0]  out_old_index,
  input  logic        out_found,
  input  logic [8:0]  out_item_count,
  input  logic [31:0] out_first_begin,
  input  logic [31:0] out_last_end,
  input  logic        out_begins_serial,
  input  logic        out_ends_serial,
  output int          errors,
  output int          outstanding
);

  localparam int BEG_TAB = 0;
  localparam int END_TAB = 1;
  localparam int TAB_DEPTH = sdi_pkg::MAX_ITEMS_DEF;
  localparam int IDS = sdi_pkg::ID_COUNT;

  typedef struct {
    logic [1:0]  status;
    logic [8:0]  begin_index;
    logic [8:0]  end_index;
    logic [8:0]  old_index;
    logic        found;
    logic [8:0]  item_count;
    logic [31:0] first_begin;
    logic [31:0] last_end;
    logic        begins_serial;
    logic        ends_serial;
  } index_result_t;

  logic               id_present [IDS];
  logic signed [31:0] id_begin [IDS];
  logic signed [31:0] id_end [IDS];
  logic signed [31:0] tab_key [2][TAB_DEPTH];
  int                 tab_cnt [2][TAB_DEPTH];
  int                 tab_used [2];
  int                 held;
  index_result_t      pending_q [$];

  function automatic void clear_tables();
    for (int i = 0; i < IDS; i++) id_present[i] = 1'b0;
    for (int t = 0; t < 2; t++) begin
      tab_used[t] = 0;
      for (int i = 0; i < TAB_DEPTH; i++) tab_cnt[t][i] = 0;
    end
    held = 0;
  endfunction

  function automatic int lower_index(int t, logic signed [31:0] k);
    int i;
    i = 0;
    while (i < tab_used[t] && tab_key[t][i] < k) i++;
    return i;
  endfunction

  function automatic int add_key(int t, logic signed [31:0] k);
    int i;
    i = lower_index(t, k);
    if (i < tab_used[t] && tab_key[t][i] == k) begin
      tab_cnt[t][i]++;
    end else if (tab_used[t] < TAB_DEPTH) begin
      for (int j = tab_used[t]; j > i; j--) begin
        tab_key[t][j] = tab_key[t][j-1];
        tab_cnt[t][j] = tab_cnt[t][j-1];
      end
      tab_key[t][i] = k;
      tab_cnt[t][i] = 1;
      tab_used[t]++;
    end
    return i;
  endfunction

  function automatic int drop_key(int t, logic signed [31:0] k);
    int i;
    i = lower_index(t, k);
    if (i < tab_used[t] && tab_key[t][i] == k) begin
      if (tab_cnt[t][i] > 0) tab_cnt[t][i]--;
      if (tab_cnt[t][i] == 0) begin
        for (int j = i; j < tab_used[t] - 1; j++) begin
          tab_key[t][j] = tab_key[t][j+1];
          tab_cnt[t][j] = tab_cnt[t][j+1];
        end
        tab_used[t]--;
      end
    end
    return i;
  endfunction

  function automatic logic no_shared(int t);
    for (int i = 0; i < tab_used[t]; i++)
      if (tab_cnt[t][i] > 1) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the shadow tables and return what the block must answer.
  function automatic index_result_t apply_request(logic [2:0] req, logic [7:0] id,
                                                  logic signed [31:0] kb,
                                                  logic signed [31:0] ke);
    index_result_t r;
    int bi, ei, oi;
    logic here;
    r = '{default: '0};
    bi = 0; ei = 0; oi = 0;
    here = id_present[id];
    case (req)
      sdi_pkg::REQ_INSERT: begin
        if (here) r.status = sdi_pkg::ST_PRESENT;
        else if (held >= sdi_pkg::MAX_ITEMS_DEF) r.status = sdi_pkg::ST_FULL;
        else begin
          id_present[id] = 1'b1;
          id_begin[id] = kb;
          id_end[id] = ke;
          held++;
          bi = add_key(BEG_TAB, kb);
          ei = add_key(END_TAB, ke);
        end
      end
      sdi_pkg::REQ_REMOVE: begin
        if (!here) r.status = sdi_pkg::ST_PRESENT;
        else begin
          ei = drop_key(END_TAB, id_end[id]);
          bi = drop_key(BEG_TAB, id_begin[id]);
          id_present[id] = 1'b0;
          if (held > 0) held--;
        end
      end
      sdi_pkg::REQ_CHG_BEGIN: begin
        if (!here) r.status = sdi_pkg::ST_PRESENT;
        else begin
          oi = drop_key(BEG_TAB, id_begin[id]);
          bi = add_key(BEG_TAB, kb);
          id_begin[id] = kb;
          ei = lower_index(END_TAB, id_end[id]);
        end
      end
      sdi_pkg::REQ_CHG_END: begin
        if (!here) r.status = sdi_pkg::ST_PRESENT;
        else begin
          oi = drop_key(END_TAB, id_end[id]);
          ei = add_key(END_TAB, ke);
          id_end[id] = ke;
          bi = lower_index(BEG_TAB, id_begin[id]);
        end
      end
      sdi_pkg::REQ_CLEAR: clear_tables();
      sdi_pkg::REQ_FIND: begin
        r.found = here;
        bi = lower_index(BEG_TAB, here ? id_begin[id] : kb);
        ei = lower_index(END_TAB, here ? id_end[id] : ke);
      end
      default: ;
    endcase
    r.begin_index   = bi[8:0];
    r.end_index     = ei[8:0];
    r.old_index     = oi[8:0];
    r.item_count    = held[8:0];
    r.first_begin   = tab_used[BEG_TAB] ? tab_key[BEG_TAB][0] : 32'd0;
    r.last_end      = tab_used[END_TAB] ? tab_key[END_TAB][tab_used[END_TAB]-1] : 32'd0;
    r.begins_serial = no_shared(BEG_TAB);
    r.ends_serial   = no_shared(END_TAB);
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    index_result_t want;
    int bad;
    if (!rst_n) begin
      clear_tables();
      pending_q.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall)
        pending_q.push_back(apply_request(in_req_type, in_item_id,
                                          in_begin_pos, in_end_pos));
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0h",
                   $time, out_status);
          errors <= errors + 1;
        end else begin
          want = pending_q.pop_front();
          bad = field_diff("status", want.status, out_status)
              + field_diff("begin_index", want.begin_index, out_begin_index)
              + field_diff("end_index", want.end_index, out_end_index)
              + field_diff("old_index", want.old_index, out_old_index)
              + field_diff("found", want.found, out_found)
              + field_diff("item_count", want.item_count, out_item_count)
              + field_diff("first_begin", want.first_begin, out_first_begin)
              + field_diff("last_end", want.last_end, out_last_end)
              + field_diff("begins_serial", want.begins_serial, out_begins_serial)
              + field_diff("ends_serial", want.ends_serial, out_ends_serial);
          if (bad != 0) errors <= errors + 1;
        end
      end
      outstanding <= pending_q.size();
    end
  end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the interval index testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on sdi_pkg, the block and
// interval_index_checker.
module tb;

  localparam int RANDOM_REQS = 720;
  localparam int IDLE_LIMIT  = 20000;  // outlasts the longest change scan and shift

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_item_id = '0;
  logic [31:0] in_begin_pos = '0;
  logic [31:0] in_end_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_status;
  logic [8:0]  out_begin_index, out_end_index, out_old_index, out_item_count;
  logic        out_found, out_begins_serial, out_ends_serial;
  logic [31:0] out_first_begin, out_last_end;
  int          errors, outstanding;
  int          results_seen = 0;
  logic        gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_sorted_interval_index DUT (.*);

  interval_index_checker u_checker (.*);

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles per result, and once hold off
  // for a long stretch so the block fills up and stalls its request port.
  initial begin
    int n;
    logic held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && results_seen == 40) begin
        held_off = 1'b1;
        n = 600;
      end else begin
        n = gaps_on ? $urandom_range(0, 13) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(logic [2:0] req, logic [7:0] id, logic [31:0] b,
                              logic [31:0] e);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_item_id   <= id;
    in_begin_pos <= b;
    in_end_pos   <= e;
    do @(posedge clk); while (in_stall);
  endtask

  // Draw keys half the time from a narrow band so they collide and share counts.
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 16) - 8;
    if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_req();
    int w;
    w = $urandom_range(0, 99);
    if (w < 30) return sdi_pkg::REQ_INSERT;
    if (w < 45) return sdi_pkg::REQ_REMOVE;
    if (w < 60) return sdi_pkg::REQ_CHG_BEGIN;
    if (w < 75) return sdi_pkg::REQ_CHG_END;
    if (w < 92) return sdi_pkg::REQ_FIND;
    if (w < 94) return sdi_pkg::REQ_CLEAR;
    return 3'($urandom_range(6, 7));  // unknown codes: answered, no change
  endfunction

  initial begin
    logic [7:0] id;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tables, key extremes, shared keys, rejects, unknown codes.
    send_request(sdi_pkg::REQ_FIND, 8'd3, 32'h8000_0000, 32'h7fff_ffff);
    send_request(sdi_pkg::REQ_REMOVE, 8'd3, 32'd0, 32'd0);
    send_request(sdi_pkg::REQ_CHG_BEGIN, 8'd3, 32'd1, 32'd1);
    send_request(sdi_pkg::REQ_CHG_END, 8'd3, 32'd1, 32'd1);
    send_request(sdi_pkg::REQ_INSERT, 8'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(sdi_pkg::REQ_INSERT, 8'd255, 32'h7fff_ffff, 32'h8000_0000);
    send_request(sdi_pkg::REQ_INSERT, 8'd7, 32'd5, 32'd5);
    send_request(sdi_pkg::REQ_INSERT, 8'd8, 32'd5, 32'd5);
    send_request(sdi_pkg::REQ_INSERT, 8'd7, 32'd9, 32'd9);
    send_request(sdi_pkg::REQ_FIND, 8'd8, 32'd0, 32'd0);
    send_request(sdi_pkg::REQ_FIND, 8'd9, 32'd6, 32'hffff_fffb);
    send_request(sdi_pkg::REQ_CHG_BEGIN, 8'd7, 32'hffff_ffff, 32'd0);
    send_request(sdi_pkg::REQ_CHG_END, 8'd8, 32'd0, 32'h7fff_ffff);
    send_request(sdi_pkg::REQ_CHG_BEGIN, 8'd0, 32'h8000_0000, 32'd0);
    send_request(3'd6, 8'd0, 32'd0, 32'd0);
    send_request(3'd7, 8'd255, 32'hffff_ffff, 32'hffff_ffff);
    send_request(sdi_pkg::REQ_REMOVE, 8'd255, 32'd0, 32'd0);
    send_request(sdi_pkg::REQ_REMOVE, 8'd255, 32'd0, 32'd0);
    send_request(sdi_pkg::REQ_CLEAR, 8'd0, 32'd0, 32'd0);
    send_request(sdi_pkg::REQ_FIND, 8'd0, 32'd0, 32'd0);

    // Random: mostly a few dozen ids so edits hit present items; alternate
    // stretches with and without idling.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
      send_request(pick_req(), id, pick_key(), pick_key());

      // Once midway, fill every id so the index holds its maximum item count.
      if (n == RANDOM_REQS / 2) begin
        for (int i = 0; i < sdi_pkg::ID_COUNT; i++)
          send_request(sdi_pkg::REQ_INSERT, 8'(i), pick_key(), pick_key());
        for (int i = 0; i < 8; i++)
          send_request(3'($urandom_range(0, 5)), 8'($urandom), pick_key(), pick_key());
        send_request(sdi_pkg::REQ_CLEAR, 8'd0, 32'd0, 32'd0);
      end
    end
    in_valid <= 1'b0;

    // Let the last request reach the checker's count, then drain.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sdi_pkg.sv
hdl/sdi_ram.sv
hdl/sdi_tab.sv
hdl/dual_sorted_interval_index.sv
hdl/sdi_chk.sv
bench/interval_index_checker.sv
bench/tb.sv
